// File: src/slot_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// slot_pool_allocator_macros.svh
// Assertion macros used by the slot pool allocator checker.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle property, disabled while reset is held
`define SPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, codes and types of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

    // default pool size
    localparam int POOL_SLOTS_DEF = 128;

    // occupancy map is scanned one group of slots per cycle
    localparam int GROUP_W  = 8;
    localparam int GROUP_LG = 3;

    // transaction field widths
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 7;
    localparam int TYPE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int HW_W     = 8;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SPAWN   = 2'd0,
        CMD_DESPAWN = 2'd1,
        CMD_READ    = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_UP,
        ST_SCAN_DOWN,
        ST_READ,
        ST_RESP
    } t_state;

    // request to the group scan unit
    typedef struct packed {
        logic [GROUP_W-1:0]  hit;
        logic [GROUP_LG-1:0] start;
        logic                down;
    } t_scan_req;

    // answer of the group scan unit
    typedef struct packed {
        logic                found;
        logic [GROUP_LG-1:0] pos;
    } t_scan_rsp;

endpackage

// File: src/spa_cmd_if.sv
// ----------------------------------------------------------------------------
// spa_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface spa_cmd_if;

    logic                          valid;
    logic                          ready;
    logic [spa_pkg::CMD_W-1:0]     command;
    logic [spa_pkg::IDX_W-1:0]     slot_index;
    logic [spa_pkg::TYPE_W-1:0]    spawn_type;

    modport source (
        output valid, command, slot_index, spawn_type,
        input  ready
    );

    modport sink (
        input  valid, command, slot_index, spawn_type,
        output ready
    );

endinterface

// File: src/spa_res_if.sv
// ----------------------------------------------------------------------------
// spa_res_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface spa_res_if;

    logic                          valid;
    logic                          ready;
    logic [spa_pkg::STATUS_W-1:0]  status;
    logic [spa_pkg::IDX_W-1:0]     granted_slot;
    logic [spa_pkg::TYPE_W-1:0]    slot_type;
    logic [spa_pkg::HW_W-1:0]      high_water;

    modport source (
        output valid, status, granted_slot, slot_type, high_water,
        input  ready
    );

    modport sink (
        input  valid, status, granted_slot, slot_type, high_water,
        output ready
    );

endinterface

// File: src/spa_scan.sv
// ----------------------------------------------------------------------------
// spa_scan
// Group scan unit: finds the first hit at or above a start bit, or the last
// hit at or below it, inside one group of the occupancy map.
// ----------------------------------------------------------------------------
module spa_scan (
    input  spa_pkg::t_scan_req i_req,
    output spa_pkg::t_scan_rsp o_rsp
);

    logic [spa_pkg::GROUP_W-1:0] keep;
    logic [spa_pkg::GROUP_W-1:0] masked;

    // keep bits on the search side of the start bit
    always_comb begin
        if (i_req.down) begin
            keep = {spa_pkg::GROUP_W{1'b1}} >>
                   (spa_pkg::GROUP_LG'(spa_pkg::GROUP_W - 1) - i_req.start);
        end else begin
            keep = {spa_pkg::GROUP_W{1'b1}} << i_req.start;
        end
        masked = i_req.hit & keep;
    end

    // priority encode toward the start bit
    always_comb begin
        o_rsp.found = |masked;
        o_rsp.pos   = '0;
        if (i_req.down) begin
            for (int k = 0; k < spa_pkg::GROUP_W; k++) begin
                if (masked[k]) o_rsp.pos = spa_pkg::GROUP_LG'(k);
            end
        end else begin
            for (int k = spa_pkg::GROUP_W - 1; k >= 0; k--) begin
                if (masked[k]) o_rsp.pos = spa_pkg::GROUP_LG'(k);
            end
        end
    end

endmodule

// File: src/spa_tag_ram.sv
// ----------------------------------------------------------------------------
// spa_tag_ram
// Type tag store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_tag_ram #(
    parameter int DEPTH = spa_pkg::POOL_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [spa_pkg::TYPE_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [spa_pkg::TYPE_W-1:0]  o_rdata
);

    logic [spa_pkg::TYPE_W-1:0] r_mem [DEPTH];
    logic [spa_pkg::TYPE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator
// Fixed pool of typed slots with a free hint and a high-water mark.
// ----------------------------------------------------------------------------
// One transaction at a time: the command port is ready only while the block
// is idle, and each command answers with exactly one result. Occupancy is
// kept in a flip-flop map that reset and the clear command empty at once;
// type tags live in a RAM, and a slot whose map bit is clear reads as free.
// A single group scan unit walks the map 8 slots per cycle. A clear, an
// out-of-range read or despawn and a non-shrinking despawn go from acceptance
// straight to the result; an in-range read passes a RAM read state first;
// a spawn scans 8-slot groups from the free hint up to the first free slot
// or the pool end, and a full pool whose hint is at the end answers without a scan.
// A despawn of the top active slot first walks groups downward to the next
// occupied slot. The result holds until taken, and the block returns to idle
// the cycle after that.
// ----------------------------------------------------------------------------
module slot_pool_allocator #(
    parameter int POOL_SLOTS = spa_pkg::POOL_SLOTS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    spa_cmd_if.sink    i_cmd,
    spa_res_if.source  o_res
);

    localparam int CNTW = $clog2(POOL_SLOTS + 1);
    localparam int AW   = $clog2(POOL_SLOTS);
    localparam int NGRP = (POOL_SLOTS + spa_pkg::GROUP_W - 1) / spa_pkg::GROUP_W;
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int IXW  = ((CNTW > spa_pkg::IDX_W) ? CNTW : spa_pkg::IDX_W) + 1;
    localparam int XW   = IXW + spa_pkg::GROUP_LG;

    // sequencer and datapath registers
    spa_pkg::t_state                      r_state, n_state;
    spa_pkg::t_status                     r_status, n_status;
    logic [spa_pkg::TYPE_W-1:0]           r_type, n_type;
    logic [spa_pkg::IDX_W-1:0]            r_slot, n_slot;
    logic [spa_pkg::TYPE_W-1:0]           r_tag, n_tag;
    logic [CNTW-1:0]                      r_hint, n_hint;
    logic [CNTW-1:0]                      r_mark, n_mark;
    logic [GW-1:0]                        r_grp, n_grp;
    logic [spa_pkg::GROUP_LG-1:0]         r_bit, n_bit;
    logic [NGRP-1:0][spa_pkg::GROUP_W-1:0] r_occ, n_occ;

    // decoded command transaction
    logic                                 in_acc;
    spa_pkg::t_cmd                        in_cmd;
    logic [XW-1:0]                        idx_x;
    logic                                 idx_oor;
    logic [CNTW-1:0]                      idx_c;
    logic [XW-1:0]                        hint_x;
    logic                                 hint_end;

    // scan unit hookup
    spa_pkg::t_scan_req                   scan_req;
    spa_pkg::t_scan_rsp                   scan_rsp;
    logic [spa_pkg::GROUP_W-1:0]          pad;
    logic [XW-1:0]                        grp_base;
    logic [CNTW-1:0]                      pos_c;
    logic                                 grp_last;
    logic                                 grp_first;

    // tag RAM hookup
    logic                                 ram_we;
    logic [AW-1:0]                        ram_waddr;
    logic                                 ram_re;
    logic [spa_pkg::TYPE_W-1:0]           ram_rdata;

    // command decode
    assign in_acc   = i_cmd.valid && i_cmd.ready;
    assign in_cmd   = spa_pkg::t_cmd'(i_cmd.command);
    assign idx_x    = XW'(i_cmd.slot_index);
    assign idx_oor  = idx_x >= XW'(POOL_SLOTS);
    assign idx_c    = CNTW'(i_cmd.slot_index);
    assign hint_x   = XW'(r_hint);
    assign hint_end = r_hint >= CNTW'(POOL_SLOTS);

    // current group of the map, slots past the pool end look occupied
    assign grp_base  = XW'(r_grp) << spa_pkg::GROUP_LG;
    assign grp_last  = r_grp == GW'(NGRP - 1);
    assign grp_first = r_grp == '0;

    always_comb begin
        for (int k = 0; k < spa_pkg::GROUP_W; k++) begin
            pad[k] = (grp_base + XW'(k)) >= XW'(POOL_SLOTS);
        end
    end

    always_comb begin
        scan_req.down  = r_state == spa_pkg::ST_SCAN_DOWN;
        scan_req.start = r_bit;
        scan_req.hit   = scan_req.down ? r_occ[r_grp] : ~(r_occ[r_grp] | pad);
    end

    spa_scan u_scan (
        .i_req (scan_req),
        .o_rsp (scan_rsp)
    );

    assign pos_c = CNTW'(grp_base | XW'(scan_rsp.pos));

    spa_tag_ram #(
        .DEPTH (POOL_SLOTS),
        .AW    (AW)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_type),
        .i_re    (ram_re),
        .i_raddr (AW'(i_cmd.slot_index)),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        spa_pkg::CMD_SPAWN: begin
                            n_state = hint_end ? spa_pkg::ST_RESP : spa_pkg::ST_SCAN_UP;
                        end
                        spa_pkg::CMD_DESPAWN: begin
                            if (!idx_oor && (idx_c + CNTW'(1)) == r_mark) begin
                                n_state = spa_pkg::ST_SCAN_DOWN;
                            end else begin
                                n_state = spa_pkg::ST_RESP;
                            end
                        end
                        spa_pkg::CMD_READ: begin
                            n_state = idx_oor ? spa_pkg::ST_RESP : spa_pkg::ST_READ;
                        end
                        spa_pkg::CMD_CLEAR: begin
                            n_state = spa_pkg::ST_RESP;
                        end
                        default: n_state = spa_pkg::ST_RESP;
                    endcase
                end
            end
            spa_pkg::ST_SCAN_UP: begin
                if (scan_rsp.found || grp_last) n_state = spa_pkg::ST_RESP;
            end
            spa_pkg::ST_SCAN_DOWN: begin
                if (scan_rsp.found || grp_first) n_state = spa_pkg::ST_RESP;
            end
            spa_pkg::ST_READ: begin
                n_state = spa_pkg::ST_RESP;
            end
            spa_pkg::ST_RESP: begin
                if (o_res.ready) n_state = spa_pkg::ST_IDLE;
            end
            default: n_state = spa_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_cmd.ready        = r_state == spa_pkg::ST_IDLE;
        o_res.valid        = r_state == spa_pkg::ST_RESP;
        o_res.status       = r_status;
        o_res.granted_slot = r_slot;
        o_res.slot_type    = r_tag;
        o_res.high_water   = spa_pkg::HW_W'(r_mark);
    end

    // datapath updates per state
    always_comb begin
        n_status  = r_status;
        n_type    = r_type;
        n_slot    = r_slot;
        n_tag     = r_tag;
        n_hint    = r_hint;
        n_mark    = r_mark;
        n_grp     = r_grp;
        n_bit     = r_bit;
        n_occ     = r_occ;
        ram_we    = 1'b0;
        ram_waddr = AW'(pos_c);
        ram_re    = 1'b0;
        case (r_state)
            spa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_type   = i_cmd.spawn_type;
                    n_slot   = i_cmd.slot_index;
                    n_tag    = '0;
                    n_status = spa_pkg::STAT_OK;
                    n_grp    = GW'(idx_x >> spa_pkg::GROUP_LG);
                    n_bit    = idx_x[spa_pkg::GROUP_LG-1:0];
                    case (in_cmd)
                        spa_pkg::CMD_SPAWN: begin
                            n_slot = '0;
                            n_grp  = GW'(hint_x >> spa_pkg::GROUP_LG);
                            n_bit  = hint_x[spa_pkg::GROUP_LG-1:0];
                            if (hint_end) n_status = spa_pkg::STAT_FULL;
                        end
                        spa_pkg::CMD_DESPAWN: begin
                            if (idx_oor) begin
                                n_status = spa_pkg::STAT_RANGE;
                            end else begin
                                n_occ[GW'(idx_x >> spa_pkg::GROUP_LG)]
                                     [idx_x[spa_pkg::GROUP_LG-1:0]] = 1'b0;
                                if (idx_c < r_hint) n_hint = idx_c;
                            end
                        end
                        spa_pkg::CMD_READ: begin
                            if (idx_oor) begin
                                n_status = spa_pkg::STAT_RANGE;
                            end else begin
                                ram_re = 1'b1;
                            end
                        end
                        default: begin
                            n_slot = '0;
                            n_occ  = '0;
                            n_hint = '0;
                            n_mark = '0;
                        end
                    endcase
                end
            end
            // first free slot at or above the hint
            spa_pkg::ST_SCAN_UP: begin
                if (scan_rsp.found) begin
                    ram_we                   = 1'b1;
                    n_occ[r_grp][scan_rsp.pos] = |r_type;
                    n_hint                   = pos_c + CNTW'(1);
                    if ((pos_c + CNTW'(1)) > r_mark) n_mark = pos_c + CNTW'(1);
                    n_slot                   = spa_pkg::IDX_W'(pos_c);
                    n_tag                    = r_type;
                end else if (grp_last) begin
                    n_status = spa_pkg::STAT_FULL;
                    n_slot   = '0;
                end else begin
                    n_grp = r_grp + GW'(1);
                    n_bit = '0;
                end
            end
            // highest occupied slot at or below the freed one
            spa_pkg::ST_SCAN_DOWN: begin
                if (scan_rsp.found) begin
                    n_mark = pos_c + CNTW'(1);
                end else if (grp_first) begin
                    n_mark = '0;
                end else begin
                    n_grp = r_grp - GW'(1);
                    n_bit = spa_pkg::GROUP_LG'(spa_pkg::GROUP_W - 1);
                end
            end
            // free slots read as zero whatever the RAM holds
            spa_pkg::ST_READ: begin
                n_tag = r_occ[r_grp][r_bit] ? ram_rdata : '0;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spa_pkg::ST_IDLE;
            r_hint  <= '0;
            r_mark  <= '0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            r_mark  <= n_mark;
            r_occ   <= n_occ;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_type   <= n_type;
        r_slot   <= n_slot;
        r_tag    <= n_tag;
        r_grp    <= n_grp;
        r_bit    <= n_bit;
    end

endmodule

// File: src/spa_checker.sv
// ----------------------------------------------------------------------------
// spa_checker
// Port-level checks of the slot pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "slot_pool_allocator_macros.svh"

module spa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [spa_pkg::STATUS_W-1:0]  i_res_status,
    input logic [spa_pkg::IDX_W-1:0]     i_res_slot,
    input logic [spa_pkg::TYPE_W-1:0]    i_res_type,
    input logic [spa_pkg::HW_W-1:0]      i_res_high_water
);

    // one transaction in flight: never ready while a result is offered
    `SPA_ASSERT(a_ready_excl_result, i_clk, i_rst_n, i_cmd_ready |-> !i_res_valid, "ready with result pending")

    // an accepted command closes the port for at least the next cycle
    `SPA_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready, "ready right after accept")

    // a taken result is not repeated
    `SPA_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, i_res_valid && i_res_ready, !i_res_valid, "result repeated")

    // a full pool grants nothing
    `SPA_ASSERT(a_full_empty_grant, i_clk, i_rst_n, (i_res_valid && i_res_status == spa_pkg::STAT_FULL) |-> (i_res_slot == '0 && i_res_type == '0), "full pool with grant")

    // a stalled result holds
    `SPA_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_status) && $stable(i_res_slot) && $stable(i_res_type) && $stable(i_res_high_water), "stalled result changed")

endmodule

bind slot_pool_allocator spa_checker u_spa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_status     (o_res.status),
    .i_res_slot       (o_res.granted_slot),
    .i_res_type       (o_res.slot_type),
    .i_res_high_water (o_res.high_water)
);
